>>> sv/back_overshoot_easing_core_macros.svh
// Assertion macros shared by the back overshoot easing RTL.
`ifndef BACK_OVERSHOOT_EASING_CORE_MACROS_SVH
`define BACK_OVERSHOOT_EASING_CORE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BOE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BOE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bo_ease_pkg.sv
// Package with constants and types for the back overshoot easing core.
`default_nettype none

package bo_ease_pkg;

    localparam int TIME_BITS_DEF  = 16;
    localparam int VALUE_BITS_DEF = 16;
    localparam int OVER_BITS      = 15;
    localparam int UNIT_BITS      = 16;
    localparam int FRAC_BITS      = 20;
    localparam int IDX_BITS       = 3;

    localparam logic [OVER_BITS-1:0] OVER_RESET = 15'd6970;

    localparam logic [1:0] MODE_IN    = 2'd0;
    localparam logic [1:0] MODE_OUT   = 2'd1;
    localparam logic [1:0] MODE_INOUT = 2'd2;

    localparam logic [IDX_BITS-1:0] REG_MODE  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_TOTAL = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_START = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_END   = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_OVER  = 3'd4;

    // Flags that follow an item through the curve stages.
    typedef struct packed {
        logic neg;   // subtract the overshoot term in the inner factor
        logic k38;   // in-out curve: one extra bit of final shift
        logic add1;  // add one unit to the curve value
    } curve_flags_t;

endpackage

`default_nettype wire

>>> sv/back_overshoot_easing_core.sv
// Back overshoot easing pipeline: time tick in, eased value out.
// Usage:
// The input channel (in_valid, in_stall, time_tick) takes one elapsed time tick per item.
// The output channel (out_valid, out_stall, eased_value) gives one eased value per item.
// An item is taken at a rising edge with valid high and stall low on that channel.
// Registers are written through cfg_we, cfg_index and cfg_data while the block is idle;
// the user must keep to this, as the block itself does not enforce it. The block is a
// 24-stage pipeline: 16 stages of restoring division that normalize time against
// total_time, one bit per stage, then eight stages of curve arithmetic with the wide
// cubic product split into two partial products. The result of an item is registered
// in the last stage, and throughput is one item per cycle while in_stall is low.
// When the receiver stalls, the pipeline keeps filling empty stages, and the input
// is stalled only once every stage holds an item.
// Reset empties the pipeline and loads mode ease-in, total_time one, start and end
// zero and the default overshoot of about 1.70158.
`default_nettype none

`include "back_overshoot_easing_core_macros.svh"

module back_overshoot_easing_core
    import bo_ease_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int CFG_BITS  = (TIME_BITS > VALUE_BITS)
                             ? ((TIME_BITS > OVER_BITS) ? TIME_BITS : OVER_BITS)
                             : ((VALUE_BITS > OVER_BITS) ? VALUE_BITS : OVER_BITS)
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [TIME_BITS-1:0]         time_tick,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [VALUE_BITS-1:0]      eased_value,
    input  wire logic                         cfg_we,
    input  wire logic [IDX_BITS-1:0]          cfg_index,
    input  wire logic [CFG_BITS-1:0]          cfg_data
);

    localparam int STAGES = 24;
    localparam int DIV_LAST = UNIT_BITS - 1;   // stage holding the finished quotient
    localparam int S_SET = 16;
    localparam int S_MUL = 17;
    localparam int S_INN = 18;
    localparam int S_PP  = 19;
    localparam int S_BIG = 20;
    localparam int S_F   = 21;
    localparam int S_G   = 22;
    localparam int S_RES = 23;

    localparam int XW  = 18;
    localparam int SPW = 16;
    localparam int PW  = 37;
    localparam int IW  = 38;
    localparam int SQW = 31;
    localparam int LOW = 18;
    localparam int HIW = IW - LOW;
    localparam int PLW = SQW + LOW;
    localparam int PHW = SQW + 1 + HIW;
    localparam int BW  = 72;
    localparam int FW  = 32;
    localparam int GW  = FW + VALUE_BITS + 1;

    localparam logic [STAGES-1:0] ALL_ONES = {STAGES{1'b1}};
    localparam logic signed [XW-1:0] UNIT_X     = 18'sd32768;
    localparam logic signed [XW-1:0] TWO_UNIT_X = 18'sd65536;
    localparam logic signed [BW-1:0] HALF37     = 72'sd1 <<< 36;
    localparam logic signed [BW-1:0] HALF38     = 72'sd1 <<< 37;
    localparam logic signed [FW-1:0] ONE_F      = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [GW-1:0] HALF_G     = GW'(1) << (FRAC_BITS - 1);
    localparam logic signed [GW-1:0] VMAX_G     = (GW'(1) << (VALUE_BITS - 1)) - GW'(1);
    localparam logic signed [GW-1:0] VMIN_G     = -VMAX_G - GW'(1);

    // Configuration registers.
    logic [1:0]                mode_reg;
    logic [TIME_BITS-1:0]      total_reg;
    logic [VALUE_BITS-1:0]     start_reg;
    logic [VALUE_BITS-1:0]     end_reg;
    logic [OVER_BITS-1:0]      over_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IN;
            total_reg <= TIME_BITS'(1);
            start_reg <= '0;
            end_reg   <= '0;
            over_reg  <= OVER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:  mode_reg  <= cfg_data[1:0];
                REG_TOTAL: total_reg <= cfg_data[TIME_BITS-1:0];
                REG_START: start_reg <= cfg_data[VALUE_BITS-1:0];
                REG_END:   end_reg   <= cfg_data[VALUE_BITS-1:0];
                REG_OVER:  over_reg  <= cfg_data[OVER_BITS-1:0];
                default:   ;
            endcase
        end
    end

    // In-out overshoot s * 61 / 40, rounded; divide by 8, then by 5 through
    // a reciprocal that is exact for every 18-bit value.
    logic [20:0]     s2n_reg;
    logic [SPW-1:0]  s2_reg;
    logic [20:0]     s2n_next;
    logic [SPW-1:0]  s2_next;
    logic [37:0]     s2_prod;

    always_comb
    begin
        s2n_next = 21'(over_reg) * 21'd61 + 21'd20;
        s2_prod  = 38'(s2n_reg[20:3]) * 38'd838861;
        s2_next  = s2_prod[22 +: SPW];
    end

    always_ff @(posedge clk)
    begin
        s2n_reg <= s2n_next;
        s2_reg  <= s2_next;
    end

    logic [TIME_BITS-1:0] total_eff;
    assign total_eff = (total_reg == '0) ? TIME_BITS'(1) : total_reg;

    // Pipeline flow: a stage loads when out_stall is low or it or a later stage is empty.
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] ld;

    always_comb
    begin
        for (int i = 0; i < STAGES; i++)
        begin
            ld[i] = !out_stall || ((~vld_reg & (ALL_ONES << i)) != '0);
        end
        vld_next[0] = ld[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            vld_next[i] = ld[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign in_stall  = !ld[0];
    assign out_valid = vld_reg[S_RES];

    // Restoring division u = floor(min(t, T) * 2^15 / T), one quotient bit a stage.
    logic [TIME_BITS-1:0] div_r_reg [0:DIV_LAST];
    logic [UNIT_BITS-1:0] div_q_reg [0:DIV_LAST];

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            if (time_tick >= total_eff)
            begin
                div_r_reg[0] <= '0;
                div_q_reg[0] <= UNIT_BITS'(1) << DIV_LAST;
            end
            else
            begin
                div_r_reg[0] <= time_tick;
                div_q_reg[0] <= '0;
            end
        end
    end

    for (genvar j = 1; j <= DIV_LAST; j++)
    begin : g_div
        logic [TIME_BITS:0]   r2;
        logic                 ge;
        logic [TIME_BITS:0]   diff;

        always_comb
        begin
            r2   = {div_r_reg[j-1], 1'b0};
            ge   = r2 >= {1'b0, total_eff};
            diff = r2 - {1'b0, total_eff};
        end

        always_ff @(posedge clk)
        begin
            if (ld[j])
            begin
                div_r_reg[j] <= ge ? diff[TIME_BITS-1:0] : r2[TIME_BITS-1:0];
                div_q_reg[j] <= div_q_reg[j-1] | (UNIT_BITS'(ge) << (DIV_LAST - j));
            end
        end
    end

    // Curve setup: pick the signed time x, the overshoot and the flags.
    logic [UNIT_BITS-1:0]      u;
    logic [UNIT_BITS:0]        w;
    logic signed [XW-1:0]      x_next;
    logic [SPW-1:0]            sp_next;
    curve_flags_t              fl_next;
    logic signed [XW-1:0]      x_reg;
    logic [SPW-1:0]            sp16_reg;
    curve_flags_t              fl16_reg;

    always_comb
    begin
        u = div_q_reg[DIV_LAST];
        w = {u, 1'b0};
        unique case (mode_reg)
            MODE_IN:
            begin
                x_next  = $signed({2'b00, u});
                sp_next = SPW'(over_reg);
                fl_next = '{neg: 1'b1, k38: 1'b0, add1: 1'b0};
            end
            MODE_OUT:
            begin
                x_next  = $signed({2'b00, u}) - UNIT_X;
                sp_next = SPW'(over_reg);
                fl_next = '{neg: 1'b0, k38: 1'b0, add1: 1'b1};
            end
            default:
            begin
                sp_next = s2_reg;
                if (w < 17'd32768)
                begin
                    x_next  = $signed({1'b0, w});
                    fl_next = '{neg: 1'b1, k38: 1'b1, add1: 1'b0};
                end
                else
                begin
                    x_next  = $signed({1'b0, w}) - TWO_UNIT_X;
                    fl_next = '{neg: 1'b0, k38: 1'b1, add1: 1'b1};
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ld[S_SET])
        begin
            x_reg    <= x_next;
            sp16_reg <= sp_next;
            fl16_reg <= fl_next;
        end
    end

    // (s + 1) * x and x * x.
    logic [SPW:0]              a_val;
    logic signed [PW-1:0]      a_prod_next;
    logic signed [2*XW-1:0]    sq_full;
    logic signed [PW-1:0]      a_prod_reg;
    logic [SQW-1:0]            sq17_reg;
    logic [SPW-1:0]            sp17_reg;
    curve_flags_t              fl17_reg;

    always_comb
    begin
        a_val       = {1'b0, sp16_reg} + 17'd4096;
        a_prod_next = $signed({1'b0, a_val}) * x_reg;
        sq_full     = x_reg * x_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ld[S_MUL])
        begin
            a_prod_reg <= a_prod_next;
            sq17_reg   <= sq_full[SQW-1:0];
            sp17_reg   <= sp16_reg;
            fl17_reg   <= fl16_reg;
        end
    end

    // Inner factor (s + 1) * x -/+ s.
    logic signed [IW-1:0]      term;
    logic signed [IW-1:0]      inner_next;
    logic signed [IW-1:0]      inner_reg;
    logic [SQW-1:0]            sq18_reg;
    curve_flags_t              fl18_reg;

    always_comb
    begin
        term       = $signed({7'b0, sp17_reg, 15'b0});
        inner_next = fl17_reg.neg ? (IW'(a_prod_reg) - term) : (IW'(a_prod_reg) + term);
    end

    always_ff @(posedge clk)
    begin
        if (ld[S_INN])
        begin
            inner_reg <= inner_next;
            sq18_reg  <= sq17_reg;
            fl18_reg  <= fl17_reg;
        end
    end

    // The cubic product is split into a low and a high partial product.
    logic [PLW-1:0]            pp_lo_next;
    logic signed [PHW-1:0]     pp_hi_next;
    logic [PLW-1:0]            pp_lo_reg;
    logic signed [PHW-1:0]     pp_hi_reg;
    curve_flags_t              fl19_reg;

    always_comb
    begin
        pp_lo_next = PLW'(sq18_reg) * PLW'(inner_reg[LOW-1:0]);
        pp_hi_next = $signed({1'b0, sq18_reg}) * $signed(inner_reg[IW-1:LOW]);
    end

    always_ff @(posedge clk)
    begin
        if (ld[S_PP])
        begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
            fl19_reg  <= fl18_reg;
        end
    end

    logic signed [BW-1:0]      big_next;
    logic signed [BW-1:0]      big_reg;
    curve_flags_t              fl20_reg;

    always_comb
    begin
        big_next = (BW'(pp_hi_reg) <<< LOW) + $signed({{(BW-PLW){1'b0}}, pp_lo_reg});
    end

    always_ff @(posedge clk)
    begin
        if (ld[S_BIG])
        begin
            big_reg  <= big_next;
            fl20_reg <= fl19_reg;
        end
    end

    // Round the curve value to Q.20 and add one unit where add1 is set.
    logic signed [BW-1:0]      big_rnd;
    logic signed [BW-1:0]      big_sh;
    logic signed [FW-1:0]      f_next;
    logic signed [FW-1:0]      f_reg;

    always_comb
    begin
        big_rnd = big_reg + (fl20_reg.k38 ? HALF38 : HALF37);
        big_sh  = fl20_reg.k38 ? (big_rnd >>> 38) : (big_rnd >>> 37);
        f_next  = $signed(big_sh[FW-1:0]) + (fl20_reg.add1 ? ONE_F : 32'sd0);
    end

    always_ff @(posedge clk)
    begin
        if (ld[S_F])
            f_reg <= f_next;
    end

    // Scale by end - start.
    logic signed [VALUE_BITS:0] delta;
    logic signed [GW-1:0]       g_next;
    logic signed [GW-1:0]       g_reg;

    always_comb
    begin
        delta  = $signed({end_reg[VALUE_BITS-1], end_reg})
               - $signed({start_reg[VALUE_BITS-1], start_reg});
        g_next = f_reg * delta;
    end

    always_ff @(posedge clk)
    begin
        if (ld[S_G])
            g_reg <= g_next;
    end

    // Add the start value and saturate.
    logic signed [GW-1:0]       res_full;
    logic signed [VALUE_BITS-1:0] res_next;
    logic signed [VALUE_BITS-1:0] res_reg;

    always_comb
    begin
        res_full = $signed({{(GW-VALUE_BITS){start_reg[VALUE_BITS-1]}}, start_reg})
                 + ((g_reg + HALF_G) >>> FRAC_BITS);
        if (res_full > VMAX_G)
            res_next = VMAX_G[VALUE_BITS-1:0];
        else if (res_full < VMIN_G)
            res_next = VMIN_G[VALUE_BITS-1:0];
        else
            res_next = res_full[VALUE_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ld[S_RES])
            res_reg <= res_next;
    end

    assign eased_value = res_reg;

    `BOE_ASSERT_NEXT(a_accept_fills, in_valid && !in_stall, vld_reg[0], "accepted item was not captured")
    `BOE_ASSERT_SAME(a_rem_below, vld_reg[DIV_LAST], div_r_reg[DIV_LAST] < total_eff, "division remainder out of range")
    `BOE_ASSERT_SAME(a_quot_max, vld_reg[DIV_LAST], div_q_reg[DIV_LAST] <= 16'd32768, "normalized time above one")
    `BOE_ASSERT_SAME(a_empty_ready, !vld_reg[0], !in_stall, "input stalled with an empty first stage")

endmodule

`default_nettype wire

>>> sim/tb_back_overshoot_easing_core.sv
// Self-checking testbench for the back overshoot easing core.
`timescale 1ns / 1ps
`default_nettype none

module tb_back_overshoot_easing_core;
    import bo_ease_pkg::*;

    localparam int TB_TIME_BITS  = 16;
    localparam int TB_VALUE_BITS = 16;
    localparam int TB_CFG_BITS   = 16;
    localparam int PIPE_DEPTH    = 24;
    localparam int UNIT          = 32768;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [TB_TIME_BITS-1:0]         time_tick;
    logic                            out_valid;
    logic                            out_stall;
    logic signed [TB_VALUE_BITS-1:0] eased_value;
    logic                            cfg_we;
    logic [IDX_BITS-1:0]             cfg_index;
    logic [TB_CFG_BITS-1:0]          cfg_data;

    back_overshoot_easing_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .time_tick(time_tick),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .eased_value(eased_value),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Shadow copy of the configuration registers.
    logic [1:0]  mode_q;
    logic [15:0] total_q;
    logic [15:0] start_q;
    logic [15:0] end_q;
    logic [14:0] over_q;

    logic [TB_TIME_BITS-1:0]  tick_queue[$];
    logic [TB_VALUE_BITS-1:0] eased_queue[$];

    int  errors;
    bit  hold_sender;
    bit  hold_receiver;
    bit  hold_go;
    int  burst_left;
    int  gap_left;
    int  stall_phase;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint floor_div_pow2(longint x, int k);
        longint m;
        m = longint'(1) << k;
        if (x >= 0)
            return x >>> k;
        return -((-x + m - 1) >>> k);
    endfunction

    function automatic longint round_pow2(longint x, int k);
        return floor_div_pow2(x + (longint'(1) << (k - 1)), k);
    endfunction

    function automatic logic [TB_VALUE_BITS-1:0] ease_value(logic [TB_TIME_BITS-1:0] tick);
        longint span, t, u, s, s2, w, inner, f, sv, ev, res;
        span = (total_q == 0) ? 1 : longint'(total_q);
        t = longint'(tick);
        if (t > span)
            t = span;
        u = (t << 15) / span;
        s = longint'(over_q);
        if (mode_q == MODE_IN)
        begin
            inner = (s + 4096) * u - s * UNIT;
            f = round_pow2(u * u * inner, 37);
        end
        else if (mode_q == MODE_OUT)
        begin
            w = u - UNIT;
            inner = (s + 4096) * w + s * UNIT;
            f = round_pow2(w * w * inner, 37) + (longint'(1) << 20);
        end
        else
        begin
            // Ease in-out, which mode three also selects.
            s2 = (s * 61 + 20) / 40;
            w = 2 * u;
            if (w < UNIT)
            begin
                inner = (s2 + 4096) * w - s2 * UNIT;
                f = round_pow2(w * w * inner, 38);
            end
            else
            begin
                w = w - 2 * UNIT;
                inner = (s2 + 4096) * w + s2 * UNIT;
                f = round_pow2(w * w * inner, 38) + (longint'(1) << 20);
            end
        end
        sv = longint'($signed(start_q));
        ev = longint'($signed(end_q));
        res = sv + round_pow2(f * (ev - sv), 20);
        if (res > 32767)
            res = 32767;
        if (res < -32768)
            res = -32768;
        return res[TB_VALUE_BITS-1:0];
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            time_tick  <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            automatic bit taken = in_valid && !in_stall;
            automatic bit busy  = in_valid && !taken;
            if (taken)
            begin
                eased_queue.push_back(ease_value(time_tick));
                void'(tick_queue.pop_front());
            end
            if (!busy)
            begin
                automatic int b = taken ? burst_left - 1 : burst_left;
                automatic int g = gap_left;
                if (b <= 0 && g == 0 && !taken)
                begin
                    b = $urandom_range(1, 40);
                end
                else if (b <= 0 && taken)
                begin
                    g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                if (g > 0)
                    g = g - 1;
                if (g == 0 && tick_queue.size() > 0 && !hold_sender)
                begin
                    in_valid  <= 1'b1;
                    time_tick <= tick_queue[0];
                    if (b <= 0)
                        b = $urandom_range(1, 40);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
                burst_left <= b;
                gap_left   <= g;
            end
        end
    end

    // Receiver: stalls on a rotating pattern, sometimes not at all.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (eased_queue.size() == 0)
                begin
                    $error("eased_value: unexpected item, actual %0d", eased_value);
                    errors++;
                end
                else
                begin
                    automatic logic [TB_VALUE_BITS-1:0] want = eased_queue.pop_front();
                    if (eased_value !== want)
                    begin
                        $error("eased_value: expected %0d, actual %0d",
                               $signed(want), eased_value);
                        errors++;
                    end
                end
            end
            stall_phase <= (stall_phase + 1) % 600;
            if (hold_receiver)
                out_stall <= 1'b1;
            else if (stall_phase < 200)
                out_stall <= 1'b0;
            else if (stall_phase < 400)
                out_stall <= ($urandom_range(0, 3) == 0);
            else
                out_stall <= ($urandom_range(0, 1) == 0);
        end
    end

    // Long receiver hold so that the pipeline fills and stalls the input.
    initial
    begin
        hold_receiver = 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_receiver <= 1'b1;
        repeat (150) @(posedge clk);
        hold_receiver <= 1'b0;
    end

    task automatic wait_drained();
        while (tick_queue.size() > 0 || in_valid || eased_queue.size() > 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [TB_CFG_BITS-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODE:  mode_q  = value[1:0];
            REG_TOTAL: total_q = value;
            REG_START: start_q = value;
            REG_END:   end_q   = value;
            REG_OVER:  over_q  = value[14:0];
            default: ;
        endcase
    endtask

    task automatic set_all(logic [1:0] m, logic [15:0] tot, logic [15:0] sv,
                           logic [15:0] ev, logic [14:0] ov);
        wait_drained();
        write_reg(REG_MODE, 16'(m));
        write_reg(REG_TOTAL, tot);
        write_reg(REG_START, sv);
        write_reg(REG_END, ev);
        write_reg(REG_OVER, 16'(ov));
    endtask

    // Ticks are mostly within the transition, sometimes past it.
    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                tick_queue.push_back(16'($urandom));
            else
                tick_queue.push_back(16'($urandom_range(0, total_q)));
        end
    endtask

    initial
    begin
        errors = 0;
        hold_sender = 0;
        hold_go = 0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mode_q = MODE_IN;
        total_q = 16'd1;
        start_q = '0;
        end_q = '0;
        over_q = OVER_RESET;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: start and end are both zero, so every result is zero.
        tick_queue.push_back(16'd0);
        tick_queue.push_back(16'hFFFF);

        set_all(MODE_IN, 16'd1000, 16'h8000, 16'h7FFF, 15'd6970);
        tick_queue.push_back(16'd0);
        tick_queue.push_back(16'd300);
        tick_queue.push_back(16'd1000);
        tick_queue.push_back(16'hFFFF);
        set_all(MODE_OUT, 16'd1000, 16'h7FFF, 16'h8000, 15'h7FFF);
        tick_queue.push_back(16'd0);
        tick_queue.push_back(16'd100);
        tick_queue.push_back(16'd700);
        tick_queue.push_back(16'd1001);
        set_all(MODE_INOUT, 16'hFFFF, 16'h8000, 16'h7FFF, 15'h7FFF);
        tick_queue.push_back(16'd0);
        tick_queue.push_back(16'd16000);
        tick_queue.push_back(16'd32767);
        tick_queue.push_back(16'd32768);
        tick_queue.push_back(16'hFFFF);
        // Mode three and a total time of zero.
        set_all(2'd3, 16'd0, 16'd100, 16'hFF00, 15'd0);
        tick_queue.push_back(16'd0);
        tick_queue.push_back(16'd1);
        tick_queue.push_back(16'hAAAA);
        set_all(MODE_IN, 16'd50, 16'd0, 16'd1000, 15'd4096);
        // Writes to unused indexes must change nothing.
        write_reg(3'd5, 16'hFFFF);
        write_reg(3'd7, 16'h1234);
        tick_queue.push_back(16'd25);
        tick_queue.push_back(16'h5555);

        for (int phase = 0; phase < 14; phase++)
        begin
            set_all(2'($urandom_range(0, 3)),
                    (phase % 5 == 0) ? 16'hFFFF : 16'($urandom_range(1, 2000)),
                    16'($urandom), 16'($urandom),
                    (phase % 4 == 0) ? 15'h7FFF : 15'($urandom));
            queue_random(100);
            if (phase == 3)
                hold_go = 1;
        end
        wait_drained();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> back_overshoot_easing_core.f
+incdir+sv
sv/bo_ease_pkg.sv
sv/back_overshoot_easing_core.sv
sim/tb_back_overshoot_easing_core.sv
